>>> src/raised_cosine_fade_in_defines.svh
// Assertion macros used by the port-level checker of the fade-in block
`ifndef RAISED_COSINE_FADE_IN_DEFINES_SVH
`define RAISED_COSINE_FADE_IN_DEFINES_SVH

// Check that the effect holds in the same cycle as the cause
`define RCFI_ASSERT_SAME(label, cause, effect) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |-> (effect)) \
        else $error("rcfi check failed");

// Check that the effect holds in the cycle after the cause
`define RCFI_ASSERT_NEXT(label, cause, effect) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
        else $error("rcfi check failed");

`endif

>>> src/rcfi_pkg.sv
// Shared constants, types and gain table function of the raised-cosine fade-in block
`timescale 1ns / 1ps
`default_nettype none

package rcfi_pkg;

    localparam int SAMPLE_BITS_DEF     = 24;
    localparam int TABLE_ADDR_BITS_DEF = 10;
    localparam int MAX_CHANNELS_DEF    = 8;
    localparam int QUEUE_DEPTH         = 4;
    localparam int PADDR_BITS          = 3;
    localparam int DATA_BITS           = 32;
    localparam int DIV_STEPS           = 17;

    localparam logic [16:0] FULL_PHASE          = 17'h10000;
    localparam logic [3:0]  CHANNEL_COUNT_RESET = 4'd2;
    localparam logic [15:0] FADE_FRAMES_RESET   = 16'd64;
    localparam logic [16:0] STEP_Q_RESET        = 17'(32'h10000 / 32'(FADE_FRAMES_RESET));
    localparam logic [15:0] STEP_R_RESET        = 16'(32'h10000 % 32'(FADE_FRAMES_RESET));

    localparam longint unsigned PI_Q30 = 64'd3373259426;

    typedef enum logic {
        REG_CHANNEL_COUNT = 1'b0,
        REG_FADE_FRAMES   = 1'b1
    } reg_index_t;

    typedef enum logic {
        DIV_IDLE,
        DIV_RUN
    } div_state_t;

    // Register values and write strobe handed to the front end and step divider
    typedef struct packed {
        logic [3:0]  channel_count;
        logic [15:0] fade_frames;
        logic        fade_wr;
        logic [15:0] fade_wdata;
    } cfg_t;

    // Phase step and divider status
    typedef struct packed {
        logic        busy;
        logic [16:0] quotient;
        logic [15:0] remainder;
    } step_t;

    // Unsigned quotient by shift and subtract; only evaluated for constant table entries
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            quo = {quo[62:0], 1'b0};
            if (rem >= den)
            begin
                rem    = rem - den;
                quo[0] = 1'b1;
            end
        end
        return quo;
    endfunction

    // One entry of sin^2(pi*i/2^(A+1)) in Q0.16 from Q30 Taylor terms
    function automatic logic [15:0] gain_entry(input int unsigned idx,
                                               input int unsigned addr_bits);
        logic [63:0]        y;
        logic [63:0]        y2;
        logic [63:0]        term;
        logic [63:0]        den;
        logic [63:0]        mag;
        logic [63:0]        g;
        logic signed [63:0] sum;
        y    = (64'(idx) * PI_Q30) >> (addr_bits + 1);
        y2   = (y * y) >> 30;
        term = y;
        sum  = $signed(y);
        for (int n = 1; n <= 8; n++)
        begin
            den  = 64'((2 * n) * (2 * n + 1));
            term = udiv64((term * y2) >> 30, den);
            if ((n & 1) != 0)
            begin
                sum = sum - $signed(term);
            end
            else
            begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0)
        begin
            sum = 64'sd0;
        end
        if (sum > 64'sd1073741824)
        begin
            sum = 64'sd1073741824;
        end
        mag = 64'(sum);
        g   = (mag * mag + (64'd1 << 43)) >> 44;
        if (g > 64'd65535)
        begin
            g = 64'd65535;
        end
        return 16'(g);
    endfunction

endpackage

`default_nettype wire

>>> src/rcfi_if.sv
// Stream interfaces for input samples and faded results
`timescale 1ns / 1ps
`default_nettype none

interface rcfi_in_if #(parameter int SAMPLE_BITS = rcfi_pkg::SAMPLE_BITS_DEF);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          packet_start;

    modport source (output valid, output sample, output packet_start, input ready);
    modport sink   (input valid, input sample, input packet_start, output ready);
endinterface

interface rcfi_out_if #(parameter int SAMPLE_BITS = rcfi_pkg::SAMPLE_BITS_DEF);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] faded_sample;
    logic                          in_fade;

    modport source (output valid, output faded_sample, output in_fade, input ready);
    modport sink   (input valid, input faded_sample, input in_fade, output ready);
endinterface

`default_nettype wire

>>> src/rcfi_queue.sv
// Short FIFO between the classifying front end and the gain back end
`timescale 1ns / 1ps
`default_nettype none

module rcfi_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = rcfi_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    // Advance pointers with wrap at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the entry
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> src/rcfi_step_div.sv
// Bit-serial divider that derives the phase step 65536 / fade_frames
`timescale 1ns / 1ps
`default_nettype none

module rcfi_step_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [15:0]        divisor,
    output rcfi_pkg::step_t    step
);

    localparam int NW = $clog2(rcfi_pkg::DIV_STEPS + 1);

    rcfi_pkg::div_state_t state_reg;
    rcfi_pkg::div_state_t state_next;

    logic [NW-1:0] count_reg;
    logic [15:0]   div_reg;
    logic [15:0]   rem_reg;
    logic [16:0]   quo_reg;
    logic [16:0]   step_q_reg;
    logic [15:0]   step_r_reg;
    logic [16:0]   trial;
    logic          fits;
    logic [15:0]   rem_new;
    logic [16:0]   quo_new;
    logic          last;

    // Shift in one dividend bit and try a subtract
    assign trial   = {rem_reg, quo_reg[16]};
    assign fits    = (trial >= {1'b0, div_reg});
    assign rem_new = fits ? 16'(trial - {1'b0, div_reg}) : trial[15:0];
    assign quo_new = {quo_reg[15:0], fits};
    assign last    = (count_reg == NW'(1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rcfi_pkg::DIV_IDLE:
            begin
                if (start && (divisor != '0))
                begin
                    state_next = rcfi_pkg::DIV_RUN;
                end
            end
            rcfi_pkg::DIV_RUN:
            begin
                if (last)
                begin
                    state_next = rcfi_pkg::DIV_IDLE;
                end
            end
            default:
            begin
                state_next = rcfi_pkg::DIV_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        step.busy      = (state_reg == rcfi_pkg::DIV_RUN);
        step.quotient  = step_q_reg;
        step.remainder = step_r_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= rcfi_pkg::DIV_IDLE;
            count_reg  <= '0;
            step_q_reg <= rcfi_pkg::STEP_Q_RESET;
            step_r_reg <= rcfi_pkg::STEP_R_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (start)
            begin
                count_reg <= NW'(rcfi_pkg::DIV_STEPS);
                if (divisor == '0)
                begin
                    step_q_reg <= '0;
                    step_r_reg <= '0;
                end
            end
            else if (state_reg == rcfi_pkg::DIV_RUN)
            begin
                count_reg <= count_reg - 1'b1;
                if (last)
                begin
                    step_q_reg <= quo_new;
                    step_r_reg <= rem_new;
                end
            end
        end
    end

    // Working registers of the division
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= rcfi_pkg::FULL_PHASE;
        end
        else if (state_reg == rcfi_pkg::DIV_RUN)
        begin
            rem_reg <= rem_new;
            quo_reg <= quo_new;
        end
    end

endmodule

`default_nettype wire

>>> src/rcfi_front.sv
// Front end: accepts samples, tracks frame, channel and phase, classifies each sample
`timescale 1ns / 1ps
`default_nettype none

module rcfi_front #(
    parameter int SAMPLE_BITS     = rcfi_pkg::SAMPLE_BITS_DEF,
    parameter int TABLE_ADDR_BITS = rcfi_pkg::TABLE_ADDR_BITS_DEF,
    parameter int MAX_CHANNELS    = rcfi_pkg::MAX_CHANNELS_DEF
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       in_valid,
    output logic                                       in_ready,
    input  logic signed [SAMPLE_BITS-1:0]              sample,
    input  logic                                       packet_start,
    input  rcfi_pkg::cfg_t                             cfg,
    input  rcfi_pkg::step_t                            step,
    input  logic                                       queue_full,
    output logic                                       push,
    output logic [SAMPLE_BITS+TABLE_ADDR_BITS+1:0]     push_data
);

    localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam logic [4:0] MAX_C = 5'(MAX_CHANNELS);

    logic [15:0]   frame_index_reg;
    logic [15:0]   frame_index_next;
    logic [CW-1:0] chan_pos_reg;
    logic [CW-1:0] chan_pos_next;
    logic [16:0]   phase_q_reg;
    logic [16:0]   phase_q_next;
    logic [15:0]   phase_r_reg;
    logic [15:0]   phase_r_next;

    logic          accept;
    logic [15:0]   fi_cur;
    logic [CW-1:0] cp_cur;
    logic [16:0]   pq_cur;
    logic [15:0]   pr_cur;
    logic          fading;
    logic [4:0]    cc_ext;
    logic [4:0]    chans;
    logic          frame_end;
    logic [16:0]   rem_sum;
    logic          wrap;
    logic [16:0]   rem_adj;
    logic [17:0]   quo_sum;
    logic [16:0]   quo_clamped;

    assign in_ready = !queue_full && !step.busy && !cfg.fade_wr;
    assign accept   = in_valid && in_ready;

    // Restart counters and load the phase on a packet start
    assign fi_cur = packet_start ? '0 : frame_index_reg;
    assign cp_cur = packet_start ? '0 : chan_pos_reg;
    assign pq_cur = packet_start ? step.quotient : phase_q_reg;
    assign pr_cur = packet_start ? step.remainder : phase_r_reg;

    // Classify the sample
    assign fading    = (cfg.fade_frames != '0) && (fi_cur < cfg.fade_frames);
    assign push      = accept;
    assign push_data = {sample, fading, pq_cur[16], pq_cur[15 -: TABLE_ADDR_BITS]};

    // Clamp the channel count to the supported range
    assign cc_ext = {1'b0, cfg.channel_count};
    always_comb
    begin
        if (cc_ext == '0)
        begin
            chans = 5'd1;
        end
        else if (cc_ext > MAX_C)
        begin
            chans = MAX_C;
        end
        else
        begin
            chans = cc_ext;
        end
    end
    assign frame_end = ((5'(cp_cur) + 5'd1) >= chans);

    // Advance the quotient/remainder phase accumulator
    assign rem_sum     = {1'b0, pr_cur} + {1'b0, step.remainder};
    assign wrap        = (rem_sum >= {1'b0, cfg.fade_frames});
    assign rem_adj     = wrap ? rem_sum - {1'b0, cfg.fade_frames} : rem_sum;
    assign quo_sum     = {1'b0, pq_cur} + {1'b0, step.quotient} + 18'(wrap);
    assign quo_clamped = (quo_sum > {1'b0, rcfi_pkg::FULL_PHASE}) ?
                         rcfi_pkg::FULL_PHASE : quo_sum[16:0];

    // Next counter state
    always_comb
    begin
        frame_index_next = frame_index_reg;
        chan_pos_next    = chan_pos_reg;
        phase_q_next     = phase_q_reg;
        phase_r_next     = phase_r_reg;
        if (cfg.fade_wr)
        begin
            frame_index_next = cfg.fade_wdata;
        end
        else if (accept)
        begin
            phase_q_next = pq_cur;
            phase_r_next = pr_cur;
            if (frame_end)
            begin
                chan_pos_next    = '0;
                frame_index_next = (fi_cur != 16'hFFFF) ? fi_cur + 1'b1 : fi_cur;
                if (fading)
                begin
                    phase_q_next = quo_clamped;
                    phase_r_next = rem_adj[15:0];
                end
            end
            else
            begin
                chan_pos_next    = cp_cur + 1'b1;
                frame_index_next = fi_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_index_reg <= '0;
            chan_pos_reg    <= '0;
            phase_q_reg     <= '0;
            phase_r_reg     <= '0;
        end
        else
        begin
            frame_index_reg <= frame_index_next;
            chan_pos_reg    <= chan_pos_next;
            phase_q_reg     <= phase_q_next;
            phase_r_reg     <= phase_r_next;
        end
    end

endmodule

`default_nettype wire

>>> src/rcfi_back.sv
// Back end: gain table lookup, multiply and output register
`timescale 1ns / 1ps
`default_nettype none

module rcfi_back #(
    parameter int SAMPLE_BITS     = rcfi_pkg::SAMPLE_BITS_DEF,
    parameter int TABLE_ADDR_BITS = rcfi_pkg::TABLE_ADDR_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   queue_empty,
    input  logic [SAMPLE_BITS+TABLE_ADDR_BITS+1:0] queue_data,
    output logic                                   pop,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [SAMPLE_BITS-1:0]          faded_sample,
    output logic                                   in_fade
);

    localparam int TABLE_SIZE = 1 << TABLE_ADDR_BITS;
    localparam int A          = TABLE_ADDR_BITS;
    localparam int SB         = SAMPLE_BITS;

    logic [15:0] gain_table [TABLE_SIZE];

    // Build the raised-cosine gain table
    for (genvar i = 0; i < TABLE_SIZE; i++)
    begin : g_gain
        localparam logic [15:0] GAIN_VALUE = rcfi_pkg::gain_entry(i, TABLE_ADDR_BITS);
        assign gain_table[i] = GAIN_VALUE;
    end

    logic signed [SB-1:0] q_sample;
    logic                 q_fading;
    logic                 q_full;
    logic [A-1:0]         q_addr;

    logic                 s1_valid_reg;
    logic signed [SB-1:0] s1_sample_reg;
    logic                 s1_fading_reg;
    logic                 s1_full_reg;
    logic [15:0]          rom_q_reg;
    logic                 out_valid_reg;
    logic signed [SB-1:0] out_sample_reg;
    logic                 out_fade_reg;

    logic                 s1_ready;
    logic                 s2_ready;
    logic [16:0]          gain;
    logic signed [SB+17:0] product;
    logic signed [SB-1:0] scaled;

    assign q_sample = queue_data[SB+A+1 : A+2];
    assign q_fading = queue_data[A+1];
    assign q_full   = queue_data[A];
    assign q_addr   = queue_data[A-1:0];

    // Stage handshake
    assign s2_ready = !out_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign pop      = !queue_empty && s1_ready;

    // Apply the gain with an arithmetic shift
    assign gain    = s1_full_reg ? rcfi_pkg::FULL_PHASE : {1'b0, rom_q_reg};
    assign product = s1_sample_reg * $signed({1'b0, gain});
    assign scaled  = product[SB+15:16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= pop;
            end
            if (s2_ready)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Lookup stage
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_sample_reg <= q_sample;
            s1_fading_reg <= q_fading;
            s1_full_reg   <= q_full;
            rom_q_reg     <= gain_table[q_addr];
        end
    end

    // Output stage
    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            out_sample_reg <= s1_fading_reg ? scaled : s1_sample_reg;
            out_fade_reg   <= s1_fading_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign faded_sample = out_sample_reg;
    assign in_fade      = out_fade_reg;

endmodule

`default_nettype wire

>>> src/raised_cosine_fade_in.sv
// Top level of the raised-cosine fade-in gain ramp
//
// Usage: interleaved signed samples enter on sample_stream (valid/ready) with a
// packet_start mark on the first sample of a packet; each sample leaves on
// faded_stream scaled by 0.5*(1-cos(pi*(k+1)/N)) while frame k is below N, with
// in_fade set, or unchanged once the fade is over or when N is zero.
// Registers on the APB port: channel_count at 0x0, fade_frames at 0x4.
// Throughput: one sample per cycle while sample_stream.ready is high. A result
// passes the gain table read stage and then the multiply into the output
// register. A four-entry queue parts the front end from the gain stages.
// Writing a nonzero fade_frames starts a bit-serial division for the phase step;
// sample_stream.ready stays low in the write cycle and while it runs.
// Reset: channel_count 2, fade_frames 64 with its step preloaded, counters and
// phase cleared; no clearing pass, the block takes samples right after reset.
// Receiver stall: the output register holds its transaction, the queue fills,
// and sample_stream.ready drops once the queue is full.
`timescale 1ns / 1ps
`default_nettype none

module raised_cosine_fade_in #(
    parameter int SAMPLE_BITS     = rcfi_pkg::SAMPLE_BITS_DEF,
    parameter int TABLE_ADDR_BITS = rcfi_pkg::TABLE_ADDR_BITS_DEF,
    parameter int MAX_CHANNELS    = rcfi_pkg::MAX_CHANNELS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    rcfi_in_if.sink                             sample_stream,
    rcfi_out_if.source                          faded_stream,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rcfi_pkg::PADDR_BITS-1:0]     paddr,
    input  logic [rcfi_pkg::DATA_BITS-1:0]      pwdata,
    output logic [rcfi_pkg::DATA_BITS-1:0]      prdata,
    output logic                                pready
);

    localparam int ENTRY_W = SAMPLE_BITS + TABLE_ADDR_BITS + 2;

    logic [3:0]           channel_count_reg;
    logic [15:0]          fade_frames_reg;
    logic                 wr_en;
    rcfi_pkg::reg_index_t reg_index;
    rcfi_pkg::cfg_t       cfg;
    rcfi_pkg::step_t      step;

    logic               push;
    logic [ENTRY_W-1:0] push_data;
    logic               queue_full;
    logic               pop;
    logic [ENTRY_W-1:0] pop_data;
    logic               queue_empty;

    // Register port
    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite;
    assign reg_index = rcfi_pkg::reg_index_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_count_reg <= rcfi_pkg::CHANNEL_COUNT_RESET;
            fade_frames_reg   <= rcfi_pkg::FADE_FRAMES_RESET;
        end
        else if (wr_en)
        begin
            case (reg_index)
                rcfi_pkg::REG_CHANNEL_COUNT: channel_count_reg <= pwdata[3:0];
                rcfi_pkg::REG_FADE_FRAMES:   fade_frames_reg   <= pwdata[15:0];
                default:                     ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        case (reg_index)
            rcfi_pkg::REG_CHANNEL_COUNT: prdata = rcfi_pkg::DATA_BITS'(channel_count_reg);
            rcfi_pkg::REG_FADE_FRAMES:   prdata = rcfi_pkg::DATA_BITS'(fade_frames_reg);
            default:                     prdata = '0;
        endcase
    end

    // Settings seen by the front end and divider
    always_comb
    begin
        cfg.channel_count = channel_count_reg;
        cfg.fade_frames   = fade_frames_reg;
        cfg.fade_wr       = wr_en && (reg_index == rcfi_pkg::REG_FADE_FRAMES);
        cfg.fade_wdata    = pwdata[15:0];
    end

    rcfi_step_div u_step_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cfg.fade_wr),
        .divisor (cfg.fade_wdata),
        .step    (step)
    );

    rcfi_front #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
        .MAX_CHANNELS    (MAX_CHANNELS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (sample_stream.valid),
        .in_ready     (sample_stream.ready),
        .sample       (sample_stream.sample),
        .packet_start (sample_stream.packet_start),
        .cfg          (cfg),
        .step         (step),
        .queue_full   (queue_full),
        .push         (push),
        .push_data    (push_data)
    );

    rcfi_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (rcfi_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (queue_empty)
    );

    rcfi_back #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .queue_empty  (queue_empty),
        .queue_data   (pop_data),
        .pop          (pop),
        .out_valid    (faded_stream.valid),
        .out_ready    (faded_stream.ready),
        .faded_sample (faded_stream.faded_sample),
        .in_fade      (faded_stream.in_fade)
    );

endmodule

`default_nettype wire

>>> src/rcfi_checker.sv
// Port-level checker of the fade-in block and its bind to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "raised_cosine_fade_in_defines.svh"

module rcfi_checker #(
    parameter int SAMPLE_BITS = rcfi_pkg::SAMPLE_BITS_DEF
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [SAMPLE_BITS-1:0]           out_sample,
    input logic                             in_fade,
    input logic                             psel,
    input logic                             penable,
    input logic                             pwrite,
    input logic [rcfi_pkg::PADDR_BITS-1:0]  paddr,
    input logic [rcfi_pkg::DATA_BITS-1:0]   pwdata,
    input logic [rcfi_pkg::DATA_BITS-1:0]   prdata
);

    // Hold a stalled result transaction
    `RCFI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    `RCFI_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_sample) && $stable(in_fade))

    // A nonzero fade length write starts the step division and holds off samples
    `RCFI_ASSERT_NEXT(a_fade_write_stalls, psel && penable && pwrite && (paddr[2] == rcfi_pkg::REG_FADE_FRAMES) && (pwdata[15:0] != 16'd0), !in_ready)

    // A channel count write reads back on the next cycle
    `RCFI_ASSERT_SAME(a_count_readback, $past(rst_n) && $past(psel && penable && pwrite && (paddr[2] == rcfi_pkg::REG_CHANNEL_COUNT)) && psel && !pwrite && (paddr[2] == rcfi_pkg::REG_CHANNEL_COUNT), prdata[3:0] == $past(pwdata[3:0]))

endmodule

bind raised_cosine_fade_in rcfi_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_rcfi_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (sample_stream.ready),
    .out_valid  (faded_stream.valid),
    .out_ready  (faded_stream.ready),
    .out_sample (faded_stream.faded_sample),
    .in_fade    (faded_stream.in_fade),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata)
);

`default_nettype wire

>>> tb/sv/raised_cosine_fade_in_checker.sv
// Checker that predicts and compares the faded sample stream of the fade-in block
`timescale 1ns / 1ps

module raised_cosine_fade_in_checker
    import rcfi_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    rcfi_in_if                    sample_mon,
    rcfi_out_if                   faded_mon,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0]  pwdata,
    input  logic [DATA_BITS-1:0]  prdata,
    input  logic                  pready,
    output int                    fail_count,
    output int                    outstanding
);

    localparam int SAMPLE_W    = SAMPLE_BITS_DEF;
    localparam int ADDR_W      = TABLE_ADDR_BITS_DEF;
    localparam int CHAN_MAX    = MAX_CHANNELS_DEF;
    localparam int TABLE_DEPTH = 1 << ADDR_W;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] faded;
        logic                       in_fade;
    } fade_result_t;

    // sin^2 gain table in Q0.16, built from fixed-point Taylor terms of sin
    logic [15:0] gain_lut [TABLE_DEPTH];

    // Register copies and ramp state
    logic [3:0]  chan_count_reg;
    logic [15:0] fade_len;
    logic [15:0] frame_cnt;
    int unsigned chan_pos;
    logic [16:0] phase_q;
    logic [15:0] phase_r;
    logic [16:0] step_q;
    logic [15:0] step_r;

    fade_result_t expected_q[$];
    int           errs;

    function automatic logic [15:0] sin2_q16(input int unsigned idx);
        longint unsigned ang;
        longint unsigned ang_sq;
        longint unsigned term;
        longint unsigned mag;
        longint unsigned g;
        longint          acc;
        ang    = idx;
        ang    = (ang * PI_Q30) >> (ADDR_W + 1);
        ang_sq = (ang * ang) >> 30;
        term   = ang;
        acc    = longint'(ang);
        for (int n = 1; n <= 8; n++)
        begin
            term = ((term * ang_sq) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
            begin
                acc = acc - longint'(term);
            end
            else
            begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0)
        begin
            acc = 0;
        end
        if (acc > (longint'(1) << 30))
        begin
            acc = longint'(1) << 30;
        end
        mag = longint'(acc);
        g   = (mag * mag + (64'd1 << 43)) >> 44;
        if (g > 64'd65535)
        begin
            g = 64'd65535;
        end
        return g[15:0];
    endfunction

    initial
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            gain_lut[i] = sin2_q16(i);
        end
    end

    // Derive the per-frame phase step from the fade length
    task automatic load_step(input logic [15:0] frames);
        if (frames == 16'd0)
        begin
            step_q = '0;
            step_r = '0;
        end
        else
        begin
            step_q = 17'(32'h10000 / frames);
            step_r = 16'(32'h10000 % frames);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : predict_and_compare
        fade_result_t               want;
        fade_result_t               got;
        logic signed [SAMPLE_W-1:0] smp;
        logic [DATA_BITS-1:0]       reg_val;
        longint                     prod;
        int unsigned                gain;
        int unsigned                lanes;
        int unsigned                rem_sum;
        int unsigned                quo_sum;
        logic                       fading;
        if (!rst_n)
        begin
            chan_count_reg = CHANNEL_COUNT_RESET;
            fade_len       = FADE_FRAMES_RESET;
            frame_cnt      = '0;
            chan_pos       = 0;
            phase_q        = '0;
            phase_r        = '0;
            load_step(FADE_FRAMES_RESET);
            expected_q.delete();
            errs           = 0;
            fail_count     <= 0;
            outstanding    <= 0;
        end
        else
        begin
            // Apply register writes; the block is idle whenever one happens
            if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00)
            begin
                case (reg_index_t'(paddr[2]))
                    REG_CHANNEL_COUNT: chan_count_reg = pwdata[3:0];
                    REG_FADE_FRAMES:
                    begin
                        fade_len  = pwdata[15:0];
                        load_step(fade_len);
                        frame_cnt = fade_len;
                    end
                    default: ;
                endcase
            end

            // Check register read-back
            if (psel && penable && !pwrite && pready && paddr[1:0] == 2'b00)
            begin
                if (reg_index_t'(paddr[2]) == REG_CHANNEL_COUNT)
                begin
                    reg_val = DATA_BITS'(chan_count_reg);
                end
                else
                begin
                    reg_val = DATA_BITS'(fade_len);
                end
                if (prdata !== reg_val)
                begin
                    $display("%0t: register read at 0x%0h expected 0x%0h, got 0x%0h",
                             $time, paddr, reg_val, prdata);
                    errs++;
                end
            end

            // Compare each result transaction against the oldest prediction
            if (faded_mon.valid && faded_mon.ready)
            begin
                got.faded   = faded_mon.faded_sample;
                got.in_fade = faded_mon.in_fade;
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got %0d in_fade %0b",
                             $time, got.faded, got.in_fade);
                    errs++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.faded !== want.faded)
                    begin
                        $display("%0t: faded_sample expected %0d, got %0d",
                                 $time, want.faded, got.faded);
                        errs++;
                    end
                    if (got.in_fade !== want.in_fade)
                    begin
                        $display("%0t: in_fade expected %0b, got %0b",
                                 $time, want.in_fade, got.in_fade);
                        errs++;
                    end
                end
            end

            // Predict the result of each accepted sample transaction
            if (sample_mon.valid && sample_mon.ready)
            begin
                smp   = sample_mon.sample;
                lanes = (chan_count_reg == 4'd0) ? 1 :
                        (chan_count_reg > CHAN_MAX) ? CHAN_MAX : chan_count_reg;
                if (sample_mon.packet_start)
                begin
                    frame_cnt = '0;
                    chan_pos  = 0;
                    phase_q   = step_q;
                    phase_r   = step_r;
                end
                fading       = (fade_len != 16'd0) && (frame_cnt < fade_len);
                want.faded   = smp;
                want.in_fade = fading;
                if (fading)
                begin
                    gain = (phase_q >= FULL_PHASE) ? 32'd65536 :
                           gain_lut[phase_q >> (16 - ADDR_W)];
                    prod = longint'(smp) * longint'(gain);
                    want.faded = SAMPLE_W'(prod >>> 16);
                end
                expected_q.insert(expected_q.size(), want);

                // Advance channel, frame and phase
                if (chan_pos + 1 >= lanes)
                begin
                    chan_pos = 0;
                    if (fading)
                    begin
                        rem_sum = phase_r + step_r;
                        quo_sum = phase_q + step_q;
                        if (rem_sum >= fade_len)
                        begin
                            rem_sum = rem_sum - fade_len;
                            quo_sum = quo_sum + 1;
                        end
                        if (quo_sum > FULL_PHASE)
                        begin
                            quo_sum = FULL_PHASE;
                        end
                        phase_r = 16'(rem_sum);
                        phase_q = 17'(quo_sum);
                    end
                    if (frame_cnt != 16'hFFFF)
                    begin
                        frame_cnt = frame_cnt + 16'd1;
                    end
                end
                else
                begin
                    chan_pos = chan_pos + 1;
                end
            end

            fail_count  <= errs;
            outstanding <= expected_q.size();
        end
    end

endmodule

>>> tb/sv/raised_cosine_fade_in_tb.sv
// Testbench top: stimulus, back-pressure, watchdog and verdict for the fade-in block
`timescale 1ns / 1ps

module raised_cosine_fade_in_tb;
    import rcfi_pkg::*;

    localparam int SAMPLE_W   = SAMPLE_BITS_DEF;
    localparam int IDLE_LIMIT = 2000;
    localparam int NUM_PHASES = 14;
    localparam int PHASE_ITEMS = 88;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_BITS-1:0] paddr;
    logic [DATA_BITS-1:0]  pwdata;
    logic [DATA_BITS-1:0]  prdata;
    logic                  pready;
    int                    fail_count;
    int                    outstanding;
    bit                    burst;

    rcfi_in_if  sample_if();
    rcfi_out_if faded_if();

    raised_cosine_fade_in u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample_stream (sample_if),
        .faded_stream  (faded_if),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    raised_cosine_fade_in_checker u_fade_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_mon  (sample_if),
        .faded_mon   (faded_if),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Idle gap before a sample: mostly none, some short, a few long
    function automatic int draw_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (burst || pick < 70)
        begin
            return 0;
        end
        if (pick < 93)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 30);
    endfunction

    // Sample content: full-range random, extremes, or small values near zero
    function automatic logic [SAMPLE_W-1:0] draw_sample();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 14)
        begin
            return SAMPLE_W'($urandom());
        end
        if (pick < 16)
        begin
            return ($urandom_range(0, 1) == 1) ? {1'b0, {(SAMPLE_W-1){1'b1}}} :
                                                 {1'b1, {(SAMPLE_W-1){1'b0}}};
        end
        return SAMPLE_W'($urandom_range(0, 600) - 300);
    endfunction

    function automatic int lanes_of(input logic [3:0] cc);
        if (cc == 4'd0)
        begin
            return 1;
        end
        return (cc > MAX_CHANNELS_DEF) ? MAX_CHANNELS_DEF : int'(cc);
    endfunction

    // Drive one sample transaction and hold it until accepted
    task automatic send(input logic [SAMPLE_W-1:0] smp, input logic start);
        int gap;
        gap = draw_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            sample_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_if.valid        <= 1'b1;
        sample_if.sample       <= smp;
        sample_if.packet_start <= start;
        @(posedge clk);
        while (!sample_if.ready)
        begin
            @(posedge clk);
        end
    endtask

    // Drop valid and wait until every predicted result has come out
    task automatic settle();
        @(negedge clk);
        sample_if.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
    endtask

    // One APB access: setup cycle, then access cycle until pready
    task automatic apb_access(input logic wr, input reg_index_t r, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= PADDR_BITS'(4 * int'(r));
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write a register, then read it back
    task automatic program_reg(input reg_index_t r, input logic [31:0] data);
        apb_access(1'b1, r, data);
        apb_access(1'b0, r, 32'd0);
    endtask

    // Result-side back-pressure: random ready runs and stalls
    initial
    begin : result_backpressure
        int hi_len;
        int lo_len;
        faded_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            hi_len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150) :
                                                   $urandom_range(1, 30);
            lo_len = ($urandom_range(0, 6) == 0) ? $urandom_range(8, 40) :
                                                   $urandom_range(1, 3);
            faded_if.ready <= 1'b1;
            repeat (hi_len) @(negedge clk);
            faded_if.ready <= 1'b0;
            repeat (lo_len - 1) @(negedge clk);
        end
    end

    // Abort when nothing moves for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((sample_if.valid && sample_if.ready) || (faded_if.valid && faded_if.ready) ||
                (psel && penable && pready) || !rst_n)
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("raised_cosine_fade_in_tb: done, errors");
        $finish;
    end

    initial
    begin : stimulus
        logic [3:0]  cc;
        logic [15:0] nf;
        logic [15:0] last_nf;
        logic        start_mark;
        int          sent;
        int          span;
        int          lanes;
        int          pick;
        rst_n                  = 1'b0;
        psel                   = 1'b0;
        penable                = 1'b0;
        pwrite                 = 1'b0;
        paddr                  = '0;
        pwdata                 = '0;
        sample_if.valid        = 1'b0;
        sample_if.sample       = '0;
        sample_if.packet_start = 1'b0;
        burst                  = 1'b0;
        last_nf                = 16'd0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Samples before any packet start: phase zero, so frame 0 gets zero gain
        send(24'h7FFFFF, 1'b0);
        send(24'h800000, 1'b0);
        send(24'hFFFFFF, 1'b0);
        send(24'h000001, 1'b0);

        // Fade from reset registers, extreme samples
        send(24'h7FFFFF, 1'b1);
        send(24'h800000, 1'b0);
        send(24'hFFFFFF, 1'b0);
        send(24'h000000, 1'b0);
        send(24'h000001, 1'b0);
        send(24'hAAAAAA, 1'b0);

        // One-frame fade: full gain on frame 0, then pass-through, then restart
        settle();
        program_reg(REG_CHANNEL_COUNT, 32'd1);
        program_reg(REG_FADE_FRAMES, 32'd1);
        send(24'h7FFFFF, 1'b1);
        send(24'h800000, 1'b0);
        send(24'h800000, 1'b1);

        // Fade disabled
        settle();
        program_reg(REG_FADE_FRAMES, 32'd0);
        send(24'h7FFFFF, 1'b1);
        send(24'h800000, 1'b0);

        // Channel count zero acts as one
        settle();
        program_reg(REG_CHANNEL_COUNT, 32'd0);
        program_reg(REG_FADE_FRAMES, 32'd3);
        send(24'h400000, 1'b1);
        send(24'hC00000, 1'b0);
        send(24'h7FFFFF, 1'b0);

        // Longest fade and channel count beyond the maximum; frame count saturated
        settle();
        program_reg(REG_CHANNEL_COUNT, 32'd15);
        program_reg(REG_FADE_FRAMES, 32'd65535);
        send(24'h800000, 1'b0);
        send(24'h7FFFFF, 1'b0);
        send(24'h7FFFFF, 1'b1);
        send(24'h800000, 1'b0);

        // Random phases: new settings, then mostly well-formed packets
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            settle();
            case (ph)
                0:       cc = 4'd1;
                1:       cc = 4'd8;
                2:       cc = 4'd15;
                3:       cc = 4'd0;
                default: cc = 4'($urandom_range(0, 15));
            endcase
            pick = $urandom_range(0, 19);
            if (ph == 1)
            begin
                nf = 16'hFFFF;
            end
            else if (pick < 13)
            begin
                nf = 16'($urandom_range(1, 24));
            end
            else if (pick < 16)
            begin
                nf = 16'($urandom_range(25, 400));
            end
            else if (pick < 18)
            begin
                nf = 16'($urandom_range(0, 2));
            end
            else
            begin
                nf = 16'($urandom());
            end
            // Change channels alone on some phases so the write can land mid-frame
            program_reg(REG_CHANNEL_COUNT, 32'(cc));
            if (ph < 4 || $urandom_range(0, 4) != 0)
            begin
                program_reg(REG_FADE_FRAMES, 32'(nf));
                last_nf = nf;
            end
            else
            begin
                nf = last_nf;
            end
            burst = ($urandom_range(0, 3) == 0);
            lanes = lanes_of(cc);
            sent  = 0;
            while (sent < PHASE_ITEMS)
            begin
                start_mark = ($urandom_range(0, 9) != 0);
                if (nf == 16'd0)
                begin
                    span = $urandom_range(1, 40);
                end
                else
                begin
                    span = int'(nf) * lanes + $urandom_range(0, 2 * lanes);
                    if (span > 120)
                    begin
                        span = $urandom_range(20, 120);
                    end
                end
                if (span > PHASE_ITEMS - sent)
                begin
                    span = PHASE_ITEMS - sent;
                end
                for (int k = 0; k < span; k++)
                begin
                    if (k == 0)
                    begin
                        send(draw_sample(), start_mark);
                    end
                    else
                    begin
                        send(draw_sample(), $urandom_range(0, 32) == 0);
                    end
                end
                sent += span;
            end
        end

        settle();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("raised_cosine_fade_in_tb: done, clean");
        end
        else
        begin
            $display("raised_cosine_fade_in_tb: done, errors");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+src
src/rcfi_pkg.sv
src/rcfi_if.sv
src/rcfi_queue.sv
src/rcfi_step_div.sv
src/rcfi_front.sv
src/rcfi_back.sv
src/raised_cosine_fade_in.sv
src/rcfi_checker.sv
tb/sv/raised_cosine_fade_in_checker.sv
tb/sv/raised_cosine_fade_in_tb.sv
